### rtl/bpe_pkg.sv
package bpe_pkg;

   // storage and widths
   localparam int MAX_POINTS = 32;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;
   localparam int T_W        = 17;
   localparam int FRAC_W     = 16;
   localparam int W_W        = COORD_W + FRAC_W;
   localparam int RES_W      = 24;
   localparam int OUT_SHIFT  = W_W - RES_W;

   localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

   // request function codes
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_EVAL   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [T_W-1:0]            t_param;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] curve_x;
      logic signed [RES_W-1:0] curve_y;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic             pt_we;
      logic [IDX_W-1:0] pt_waddr;
      logic             t_load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             rd_src_pts;
      logic             res_single;
   } dp_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic signed [RES_W-1:0] res_x;
      logic signed [RES_W-1:0] res_y;
   } dp_stat_type;

endpackage

### rtl/bpe_ram.sv
module bpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bpe_datapath.sv
module bpe_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bpe_pkg::req_type     req_data,
   input  bpe_pkg::dp_cmd_type  cmd,
   output bpe_pkg::dp_stat_type stat
);
   import bpe_pkg::*;

   localparam int PTS_W  = 2 * COORD_W;
   localparam int WORK_W = 2 * W_W;
   localparam int D_W    = W_W + 1;
   localparam int PROD_W = D_W + T_W + 1;
   localparam int Q_W    = PROD_W - FRAC_W;

   // memories
   logic [PTS_W-1:0]  pts_rdata;
   logic [WORK_W-1:0] work_rdata;
   logic              work_we;
   logic [IDX_W-1:0]  work_waddr;
   logic [WORK_W-1:0] work_wdata;

   bpe_ram #(.WIDTH(PTS_W), .DEPTH(MAX_POINTS)) u_pts_ram (
      .clock (clock),
      .we    (cmd.pt_we),
      .waddr (cmd.pt_waddr),
      .wdata ({req_data.point_x, req_data.point_y}),
      .raddr (cmd.rd_addr),
      .rdata (pts_rdata)
   );

   bpe_ram #(.WIDTH(WORK_W), .DEPTH(MAX_POINTS)) u_work_ram (
      .clock (clock),
      .we    (work_we),
      .waddr (work_waddr),
      .wdata (work_wdata),
      .raddr (cmd.rd_addr),
      .rdata (work_rdata)
   );

   // pipeline registers, lane 0 is x and lane 1 is y
   logic [T_W-1:0]           t_ff;
   logic                     v_rd_ff, v_d_ff, v_p_ff;
   logic                     src_pts_ff;
   logic [IDX_W-1:0]         idx_rd_ff, idx_d_ff, idx_p_ff;
   logic signed [W_W-1:0]    prev_ff [2];
   logic signed [W_W-1:0]    a_d_ff  [2];
   logic signed [W_W-1:0]    a_p_ff  [2];
   logic signed [D_W-1:0]    d_ff    [2];
   logic signed [PROD_W-1:0] prod_ff [2];
   logic signed [W_W-1:0]    w_last_ff [2];

   logic signed [W_W-1:0]    rd_w    [2];
   logic signed [D_W-1:0]    d_in    [2];
   logic signed [PROD_W-1:0] prod_in [2];
   logic signed [PROD_W-1:0] rnd     [2];
   logic signed [Q_W-1:0]    q       [2];
   logic signed [W_W-1:0]    w_new   [2];
   logic signed [W_W-1:0]    res_src [2];
   logic signed [W_W:0]      res_rnd [2];
   logic [T_W-1:0]           t_in;

   assign t_in = (req_data.t_param > T_ONE) ? T_ONE : req_data.t_param;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rd_w[l] = src_pts_ff
            ? {pts_rdata[(1-l)*COORD_W +: COORD_W], {FRAC_W{1'b0}}}
            : work_rdata[(1-l)*W_W +: W_W];
         d_in[l]    = {rd_w[l][W_W-1], rd_w[l]} - {prev_ff[l][W_W-1], prev_ff[l]};
         prod_in[l] = d_ff[l] * $signed({1'b0, t_ff});
         // a + round((b - a) * t / one), tie toward plus infinity
         rnd[l]     = prod_ff[l] + PROD_W'(1 << (FRAC_W - 1));
         q[l]       = rnd[l][PROD_W-1:FRAC_W];
         w_new[l]   = a_p_ff[l] + q[l][W_W-1:0];
         res_src[l] = cmd.res_single ? prev_ff[l] : w_last_ff[l];
         res_rnd[l] = {res_src[l][W_W-1], res_src[l]} + (W_W+1)'(1 << (OUT_SHIFT - 1));
      end
   end

   assign work_we    = v_p_ff;
   assign work_waddr = idx_p_ff - IDX_W'(1);
   assign work_wdata = {w_new[0], w_new[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff <= 1'b0;
         v_d_ff  <= 1'b0;
         v_p_ff  <= 1'b0;
      end else begin
         v_rd_ff <= cmd.rd_en;
         v_d_ff  <= v_rd_ff && (idx_rd_ff != '0);
         v_p_ff  <= v_d_ff;
      end
      if (cmd.t_load) begin
         t_ff <= t_in;
      end
      src_pts_ff <= cmd.rd_src_pts;
      idx_rd_ff  <= cmd.rd_addr;
      idx_d_ff   <= idx_rd_ff;
      idx_p_ff   <= idx_d_ff;
      for (int l = 0; l < 2; l++) begin
         if (v_rd_ff) begin
            prev_ff[l] <= rd_w[l];
         end
         a_d_ff[l]  <= prev_ff[l];
         d_ff[l]    <= d_in[l];
         a_p_ff[l]  <= a_d_ff[l];
         prod_ff[l] <= prod_in[l];
         if (v_p_ff) begin
            w_last_ff[l] <= w_new[l];
         end
      end
   end

   assign stat.busy  = v_rd_ff || v_d_ff || v_p_ff;
   assign stat.res_x = res_rnd[0][W_W-1:OUT_SHIFT];
   assign stat.res_y = res_rnd[1][W_W-1:OUT_SHIFT];

endmodule

### rtl/bpe_controller.sv
module bpe_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bpe_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bpe_pkg::rsp_type     rsp_data,
   output bpe_pkg::dp_cmd_type  cmd,
   input  bpe_pkg::dp_stat_type stat
);
   import bpe_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] lvl_ff, lvl_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             first_ff, first_in;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             accept;
   logic             out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      lvl_in       = lvl_ff;
      rd_idx_in    = rd_idx_ff;
      first_in     = first_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      cmd            = '0;
      cmd.rd_addr    = rd_idx_ff;
      cmd.rd_src_pts = first_ff;
      cmd.res_single = (lvl_ff == CNT_W'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_START: begin
                     cmd.pt_we    = 1'b1;
                     cmd.pt_waddr = '0;
                     count_in     = CNT_W'(1);
                     dropped_in   = 1'b0;
                  end
                  FUNC_APPEND: begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        cmd.pt_we    = 1'b1;
                        cmd.pt_waddr = count_ff[IDX_W-1:0];
                        count_in     = count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  FUNC_EVAL: begin
                     cmd.t_load = 1'b1;
                     lvl_in     = count_ff;
                     rd_idx_in  = '0;
                     first_in   = 1'b1;
                     empty_in   = (count_ff == '0);
                     state_in   = (count_ff == '0) ? ST_FINISH : ST_ISSUE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (CNT_W'(rd_idx_ff) == lvl_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               if (lvl_ff <= CNT_W'(2)) begin
                  state_in = ST_FINISH;
               end else begin
                  lvl_in    = lvl_ff - CNT_W'(1);
                  rd_idx_in = '0;
                  first_in  = 1'b0;
                  state_in  = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  rsp_data_in.curve_x = '0;
                  rsp_data_in.curve_y = '0;
                  rsp_data_in.status  = STATUS_EMPTY;
               end else begin
                  rsp_data_in.curve_x = stat.res_x;
                  rsp_data_in.curve_y = stat.res_y;
                  rsp_data_in.status  = dropped_ff ? STATUS_DROPPED : STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff      <= lvl_in;
      rd_idx_ff   <= rd_idx_in;
      first_ff    <= first_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/bezier_point_evaluator_top.sv
// Bezier point evaluator. Holds up to MAX_POINTS integer control points
// (x, y) and evaluates the Bezier curve they define at a parameter t in
// unsigned Q1.16, giving x and y in signed Q16.8 rounded to nearest.
// A start beat (func 0) begins a new curve with its point and clears the
// dropped flag, an append beat (func 1) adds a point; appends past capacity
// are discarded and set the dropped flag, which shows as status 2 on every
// later result until the next start. An evaluate beat (func 2) returns one
// result beat; with no points stored it reports status 1 and zero
// coordinates. t above 1.0 is clamped to 1.0. func 3 is accepted and ignored.
// An evaluate of n points runs De Casteljau one level at a time: each level
// streams its points through a read, subtract, multiply and round pipeline
// (one multiplier per coordinate lane) and drains before the next level
// reads back the working memory. Start and append beats are taken while a
// result still waits on the result channel; an evaluate then finishes and
// holds until the result register is free.

module bezier_point_evaluator_top (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  bpe_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpe_pkg::rsp_type rsp_data
);
   import bpe_pkg::*;

   // commands from the sequencer, status back from the arithmetic
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // point count, level and read sequencing, result register
   bpe_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // point and working memories, interpolation pipeline per coordinate
   bpe_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .stat     (dp_stat)
   );

endmodule
